// ----- src/sdw_pkg.sv -----
// Package with the item types, the stage types and the constants of the digit display unit.
package sdw_pkg;

  typedef struct packed {
    logic              kind;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0] digit_address;
    logic [7:0] digit_code;
    logic       last_word;
  } out_item_t;

  typedef struct packed {
    logic       kind;
    logic       nonpos;
    logic [8:0] hi;
    logic [6:0] lo;
  } split_t;

  typedef struct packed {
    logic [3:0]      present;
    logic [3:0][7:0] code;
  } slots_t;

  localparam logic [0:0] KIND_INT = 1'b0;
  localparam logic [0:0] KIND_DEC = 1'b1;

  localparam logic [7:0] DASH_CODE  = 8'd10;
  localparam logic [7:0] POINT_FLAG = 8'h80;

  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int          SHIFT_100 = 19;
  localparam logic [8:0]  RECIP_10_HI = 9'd410;
  localparam int          SHIFT_10_HI = 12;
  localparam logic [6:0]  RECIP_10_LO = 7'd103;
  localparam int          SHIFT_10_LO = 10;

endpackage

// ----- src/sdw_split.sv -----
// Stage that takes the magnitude apart into hundreds and the remainder below one hundred.
module sdw_split import sdw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     up_valid,
  output logic     up_ready,
  input  in_item_t up_item,
  output logic     dn_valid,
  input  logic     dn_ready,
  output split_t   dn_split
);

  logic        neg;
  logic [15:0] mag;
  logic [28:0] prod;
  logic [8:0]  q;
  logic [15:0] q100;
  logic [15:0] rem;
  split_t      split_nxt;
  logic        valid_r;
  split_t      split_r;

  assign neg  = up_item.value[15];
  assign mag  = neg ? 16'(16'd0 - $unsigned(up_item.value)) : $unsigned(up_item.value);
  assign prod = {13'd0, mag} * {16'd0, RECIP_100};
  assign q    = prod[SHIFT_100 +: 9];
  assign q100 = ({7'd0, q} << 6) + ({7'd0, q} << 5) + ({7'd0, q} << 2);
  assign rem  = mag - q100;

  always_comb begin
    split_nxt.kind   = up_item.kind;
    split_nxt.nonpos = neg || (up_item.value == 16'sd0);
    split_nxt.hi     = q;
    split_nxt.lo     = rem[6:0];
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      split_r <= split_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_split = split_r;

endmodule

// ----- src/sdw_digits.sv -----
// Stage that forms the four decimal digits and the set of display words to send.
module sdw_digits import sdw_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   up_valid,
  output logic   up_ready,
  input  split_t up_split,
  output logic   dn_valid,
  input  logic   dn_ready,
  output slots_t dn_slots
);

  logic [17:0] hprod;
  logic [5:0]  hq;
  logic [8:0]  hq10;
  logic [8:0]  hrem;
  logic [13:0] lprod;
  logic [3:0]  lq;
  logic [6:0]  lq10;
  logic [6:0]  lrem;
  logic [3:0]  d3;
  logic [3:0]  d2;
  logic [3:0]  d1;
  logic [3:0]  d0;
  slots_t      slots_nxt;
  logic        valid_r;
  slots_t      slots_r;

  assign hprod = {9'd0, up_split.hi} * {9'd0, RECIP_10_HI};
  assign hq    = hprod[SHIFT_10_HI +: 6];
  assign hq10  = ({3'd0, hq} << 3) + ({3'd0, hq} << 1);
  assign hrem  = up_split.hi - hq10;
  assign lprod = {7'd0, up_split.lo} * {7'd0, RECIP_10_LO};
  assign lq    = lprod[SHIFT_10_LO +: 4];
  assign lq10  = ({3'd0, lq} << 3) + ({3'd0, lq} << 1);
  assign lrem  = up_split.lo - lq10;

  always_comb begin
    if (hq >= 6'd30) begin
      d3 = 4'(hq - 6'd30);
    end else if (hq >= 6'd20) begin
      d3 = 4'(hq - 6'd20);
    end else if (hq >= 6'd10) begin
      d3 = 4'(hq - 6'd10);
    end else begin
      d3 = hq[3:0];
    end
  end

  assign d2 = hrem[3:0];
  assign d1 = lq;
  assign d0 = lrem[3:0];

  always_comb begin
    slots_nxt.code[3] = up_split.nonpos ? DASH_CODE : {4'd0, d3};
    slots_nxt.code[2] = (up_split.kind == KIND_DEC) ? ({4'd0, d2} | POINT_FLAG) : {4'd0, d2};
    slots_nxt.code[1] = {4'd0, d1};
    slots_nxt.code[0] = {4'd0, d0};
    slots_nxt.present[0] = 1'b1;
    slots_nxt.present[3] = up_split.nonpos || (d3 != 4'd0);
    if (up_split.kind == KIND_DEC) begin
      slots_nxt.present[2] = 1'b1;
      slots_nxt.present[1] = (d1 != 4'd0);
    end else if (up_split.nonpos) begin
      slots_nxt.present[2] = (d2 != 4'd0);
      slots_nxt.present[1] = ((d2 | d1) != 4'd0);
    end else begin
      slots_nxt.present[2] = ((d3 | d2) != 4'd0);
      slots_nxt.present[1] = ((d3 | d2 | d1) != 4'd0);
    end
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      slots_r <= slots_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_slots = slots_r;

endmodule

// ----- src/sdw_emit.sv -----
// Word register that sends the pending display words one per cycle while out_ready is high, leftmost position first.
module sdw_emit import sdw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  slots_t    up_slots,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic            valid_r;
  logic [3:0]      present_r;
  logic [3:0][7:0] code_r;
  logic [3:0]      sel;
  logic [1:0]      sel_idx;
  logic            last;
  logic            take;
  logic            load;

  always_comb begin
    sel[3] = present_r[3];
    sel[2] = present_r[2] && !present_r[3];
    sel[1] = present_r[1] && !present_r[3] && !present_r[2];
    sel[0] = present_r[0] && !present_r[3] && !present_r[2] && !present_r[1];
  end

  always_comb begin
    if (sel[3]) begin
      sel_idx = 2'd3;
    end else if (sel[2]) begin
      sel_idx = 2'd2;
    end else if (sel[1]) begin
      sel_idx = 2'd1;
    end else begin
      sel_idx = 2'd0;
    end
  end

  assign last     = ((present_r & ~sel) == 4'd0);
  assign take     = valid_r && out_ready;
  assign up_ready = !valid_r || (out_ready && last);
  assign load     = up_ready && up_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      present_r <= up_slots.present;
      code_r    <= up_slots.code;
    end else if (take) begin
      present_r <= present_r & ~sel;
    end
  end

  assign out_valid              = valid_r;
  assign out_item.digit_address = {1'b0, sel_idx} + 3'd1;
  assign out_item.digit_code    = code_r[sel_idx];
  assign out_item.last_word     = last;

endmodule

// ----- src/signed_value_to_digit_display_words_unit.sv -----
// Top level of the unit that turns a signed value into display words for a four-digit display.
// Path: an accepted item passes the input register, the split stage, the digits stage and the word register.
// Output: an item yields one to four words; the word register sends one word per cycle while out_ready is high,
// and it takes the next item only as the last word of the item before it is taken.
// Reset: a synchronous low on rst_n clears every stage valid flag; payload is not reset.
module signed_value_to_digit_display_words_unit import sdw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic     in_valid_r;
  in_item_t in_item_r;
  logic     split_ready;
  logic     split_valid;
  split_t   split;
  logic     digits_ready;
  logic     slots_valid;
  slots_t   slots;
  logic     emit_ready;

  assign in_ready = !in_valid_r || split_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  sdw_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid_r),
    .up_ready (split_ready),
    .up_item  (in_item_r),
    .dn_valid (split_valid),
    .dn_ready (digits_ready),
    .dn_split (split)
  );

  sdw_digits u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (split_valid),
    .up_ready (digits_ready),
    .up_split (split),
    .dn_valid (slots_valid),
    .dn_ready (emit_ready),
    .dn_slots (slots)
  );

  sdw_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (slots_valid),
    .up_ready  (emit_ready),
    .up_slots  (slots),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

// ----- src/sdw_checker.sv -----
// Port checker for the digit display unit and the bind that attaches it.
module sdw_checker import sdw_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("Stalled result item changed or dropped.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_words_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_item.last_word |=> out_valid)
    else $error("Gap between words of one item.");

  a_words_descend: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_item.last_word |=>
      out_item.digit_address < $past(out_item.digit_address))
    else $error("Word positions of one item do not descend.");

  a_last_at_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_item.digit_address == 3'd1) == out_item.last_word))
    else $error("Final word flag does not match the rightmost position.");

endmodule

bind signed_value_to_digit_display_words_unit sdw_checker u_sdw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
